// ===== design/tpd_pkg.sv =====
package tpd_pkg;

  localparam int TEMP_W  = 13;
  localparam int FLUX_W  = 21;
  localparam int SPEED_W = 18;
  localparam int PWR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DFLUX_W = 20;
  localparam int CUR_W   = 16;
  localparam int INTEG_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int INTEG_FRAC_BITS_DEF = 16;

  // Shared shift-add multiplier and restoring divider sizes.
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 20;
  localparam int DIV_W  = 48;

  localparam logic signed [14:0] MAG_OFFSET = 15'sd1760;
  localparam logic [MUL_BW-1:0]  DECAY_Q16  = 20'd64225;
  localparam logic signed [SPEED_W-1:0] SPEED_KNEE = 18'sd2000;
  localparam logic [DIV_W-1:0]   DIV_FIVE   = 48'd5;

  localparam logic signed [TEMP_W-1:0] HOLD_TEMP_RST = 13'sd1600;
  localparam logic signed [TEMP_W-1:0] KNEE_TEMP_RST = 13'sd1440;
  localparam logic [PWR_W-1:0]   FULL_POWER_RST   = 16'd10000;
  localparam logic [PWR_W-1:0]   FLOOR_POWER_RST  = 16'd2000;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd12800;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd2560;
  localparam logic [DFLUX_W-1:0] DEFAULT_FLUX_RST = 20'd52429;
  localparam logic [CUR_W-1:0]   MAX_CURRENT_RST  = 16'd3200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_TEMP    = 3'd0,
    CFG_KNEE_TEMP    = 3'd1,
    CFG_FULL_POWER   = 3'd2,
    CFG_FLOOR_POWER  = 3'd3,
    CFG_PROP_GAIN    = 3'd4,
    CFG_INTEG_GAIN   = 3'd5,
    CFG_DEFAULT_FLUX = 3'd6,
    CFG_MAX_CURRENT  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAUNCH,
    ST_DECAY,
    ST_INC_MUL,
    ST_INC_DIV_GO,
    ST_INC_DIV,
    ST_INC_ADD,
    ST_CUT_MUL,
    ST_POWER,
    ST_DEN_GO,
    ST_DEN_MUL,
    ST_CUR_GO,
    ST_CUR_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ===== design/tpd_sample_if.sv =====
interface tpd_sample_if;
  import tpd_pkg::*;
  logic valid;
  logic ready;
  logic signed [TEMP_W-1:0]  winding_temp;
  logic signed [TEMP_W-1:0]  magnet_temp;
  logic signed [FLUX_W-1:0]  flux_estimate;
  logic signed [SPEED_W-1:0] elec_speed;
  modport source(output valid, winding_temp, magnet_temp, flux_estimate, elec_speed,
                 input ready);
  modport sink(input valid, winding_temp, magnet_temp, flux_estimate, elec_speed,
               output ready);
endinterface

// ===== design/tpd_limit_if.sv =====
interface tpd_limit_if;
  import tpd_pkg::*;
  logic valid;
  logic ready;
  logic [PWR_W-1:0] power_limit;
  logic [CUR_W-1:0] current_limit;
  modport source(output valid, power_limit, current_limit, input ready);
  modport sink(input valid, power_limit, current_limit, output ready);
endinterface

// ===== design/tpd_mul.sv =====
module tpd_mul #(
  parameter int AW = tpd_pkg::MUL_AW,
  parameter int BW = tpd_pkg::MUL_BW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   prod,
  output tpd_pkg::unit_st_t  st
);
  import tpd_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] acc;
  logic [PW-1:0] aa;
  logic [BW-1:0] bb;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  // One multiplier bit per cycle: the multiplicand shifts left, the multiplier right.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        aa   <= PW'(a);
        bb   <= b;
        cnt  <= CW'(BW);
        busy <= 1'b1;
      end else if (busy) begin
        if (bb[0]) begin
          acc <= acc + aa;
        end
        aa  <= aa << 1;
        bb  <= bb >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod    = acc;
  assign st.busy = busy;
  assign st.done = done;

endmodule

// ===== design/tpd_div.sv =====
module tpd_div #(
  parameter int DW = tpd_pkg::DIV_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic [DW-1:0]     quo,
  output tpd_pkg::unit_st_t st
);
  import tpd_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] q;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   sh;
  logic [DW:0]   diff;

  assign sh   = {rem, q[DW-1]};
  assign diff = sh - {1'b0, d};

  // Restoring division, one quotient bit per cycle, MSB first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        q    <= num;
        d    <= den;
        cnt  <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[DW]) begin
          rem <= diff[DW-1:0];
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= sh[DW-1:0];
          q   <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo     = q;
  assign st.busy = busy;
  assign st.done = done;

endmodule

// ===== design/thermal_pi_power_derating.sv =====
// Channel   Dir  Handshake      Payload
// sample    in   valid/ready    winding_temp, magnet_temp, flux_estimate, elec_speed
// limit     out  valid/ready    power_limit, current_limit
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// A transaction uses the bit-serial multiplier and the restoring divider, one after the other.
// Reset is synchronous and restores the register defaults and a zero integrator.
// A new sample is taken while a finished result waits; the block then holds its
// next result until the limit channel is free.
module thermal_pi_power_derating #(
  parameter int INTEG_FRAC_BITS = tpd_pkg::INTEG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tpd_sample_if.sink                        sample,
  tpd_limit_if.source                       limit,
  input  logic                              cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tpd_pkg::*;

  localparam int F    = INTEG_FRAC_BITS;
  localparam int SH_L = (F >= 13) ? F - 13 : 0;
  localparam int SH_R = (F >= 13) ? 0 : 13 - F;
  localparam int HI_W = 17 + F;
  localparam int T2_W = INTEG_W + 24 - F;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Configuration registers.
  logic signed [TEMP_W-1:0] hold_temp;
  logic signed [TEMP_W-1:0] knee_temp;
  logic [PWR_W-1:0]   full_power;
  logic [PWR_W-1:0]   floor_power;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [DFLUX_W-1:0] default_flux;
  logic [CUR_W-1:0]   max_current;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_temp    <= HOLD_TEMP_RST;
      knee_temp    <= KNEE_TEMP_RST;
      full_power   <= FULL_POWER_RST;
      floor_power  <= FLOOR_POWER_RST;
      prop_gain    <= PROP_GAIN_RST;
      integ_gain   <= INTEG_GAIN_RST;
      default_flux <= DEFAULT_FLUX_RST;
      max_current  <= MAX_CURRENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HOLD_TEMP:    hold_temp    <= cfg_wdata[TEMP_W-1:0];
        CFG_KNEE_TEMP:    knee_temp    <= cfg_wdata[TEMP_W-1:0];
        CFG_FULL_POWER:   full_power   <= cfg_wdata[PWR_W-1:0];
        CFG_FLOOR_POWER:  floor_power  <= cfg_wdata[PWR_W-1:0];
        CFG_PROP_GAIN:    prop_gain    <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_GAIN:   integ_gain   <= cfg_wdata[GAIN_W-1:0];
        CFG_DEFAULT_FLUX: default_flux <= cfg_wdata[DFLUX_W-1:0];
        CFG_MAX_CURRENT:  max_current  <= cfg_wdata[CUR_W-1:0];
      endcase
    end
  end

  state_t state;
  state_t state_next;

  logic signed [TEMP_W-1:0]  wt;
  logic signed [TEMP_W-1:0]  mt;
  logic signed [FLUX_W-1:0]  fx;
  logic signed [SPEED_W-1:0] sp;

  logic [INTEG_W-1:0] integrator;
  logic               cold;
  logic               err_neg;
  logic [15:0]        err_mag;
  logic               inc_neg;
  logic [DIV_W-1:0]   div_num_r;
  logic signed [DIV_W:0] inc;
  logic [48:0]        cut;
  logic [PWR_W-1:0]   power;
  logic [DIV_W-1:0]   den;
  logic [CUR_W-1:0]   iq;

  logic               mul_start;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_prod;
  unit_st_t           mul_st;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_den;
  logic [DIV_W-1:0]   div_quo;
  unit_st_t           div_st;

  tpd_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_prod), .st(mul_st)
  );

  tpd_div #(.DW(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .st(div_st)
  );

  // Controlled temperature and error.
  logic signed [14:0] scaled;
  logic signed [14:0] wt_ext;
  logic signed [14:0] tctl;
  logic signed [15:0] err;
  logic               flux_pos;
  logic               fast;
  logic [DFLUX_W-1:0] psi;

  assign flux_pos = !fx[FLUX_W-1] && (fx != '0);
  assign scaled   = 15'(mt) + 15'(hold_temp) - MAG_OFFSET;
  assign wt_ext   = 15'(wt);
  assign tctl     = (flux_pos && (scaled > wt_ext)) ? scaled : wt_ext;
  assign err      = 16'(tctl) - 16'(hold_temp);
  assign fast     = sp > SPEED_KNEE;
  assign psi      = flux_pos ? fx[DFLUX_W-1:0] : default_flux;

  // Integrator increment numerator: floor(p * 2^F / 8192), then made ready so that
  // a division of its magnitude by five gives the floor of the signed value.
  logic signed [DIV_W-1:0] p_s;
  logic signed [DIV_W-1:0] np;
  assign p_s = err_neg ? -$signed({16'b0, mul_prod[31:0]}) : $signed({16'b0, mul_prod[31:0]});
  assign np  = (p_s <<< SH_L) >>> SH_R;

  // Anti-windup bounds.
  logic signed [16:0]     span;
  logic [HI_W-1:0]        hi_w;
  logic [INTEG_W-1:0]     hi;
  logic signed [DIV_W:0]  acc;
  assign span = $signed({1'b0, full_power}) - $signed({1'b0, floor_power});
  assign hi_w = span[16] || (span == '0) ? '0 : (HI_W'(span[15:0]) << F);
  assign hi   = (hi_w > HI_W'({INTEG_W{1'b1}})) ? {INTEG_W{1'b1}} : hi_w[INTEG_W-1:0];
  assign acc  = $signed({17'b0, integrator}) + inc;

  // Proportional and integral cut in W * 2^-24.
  logic [41:0]           term1;
  logic [T2_W-1:0]       term2;
  logic signed [49:0]    cut_s;
  assign term1 = {mul_prod[29:0], 12'b0};
  assign term2 = T2_W'(integrator) << (24 - F);
  assign cut_s = err_neg ? $signed(50'(term2)) - $signed(50'(term1))
                         : $signed(50'(term2)) + $signed(50'(term1));

  logic signed [51:0] x;
  logic signed [51:0] full_s;
  logic signed [51:0] floor_s;
  assign full_s  = $signed({12'b0, full_power, 24'b0});
  assign floor_s = $signed({12'b0, floor_power, 24'b0});
  assign x       = full_s - $signed({3'b0, cut});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = div_num_r;
    div_den      = DIV_FIVE;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = ST_PREP;
      end
      ST_PREP: state_next = ST_LAUNCH;
      ST_LAUNCH: begin
        mul_start = 1'b1;
        if (cold) begin
          mul_a      = integrator;
          mul_b      = DECAY_Q16;
          state_next = ST_DECAY;
        end else begin
          mul_a      = MUL_AW'(integ_gain);
          mul_b      = MUL_BW'(err_mag);
          state_next = ST_INC_MUL;
        end
      end
      ST_DECAY:   if (mul_st.done) state_next = ST_DEN_GO;
      ST_INC_MUL: if (mul_st.done) state_next = ST_INC_DIV_GO;
      ST_INC_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_INC_DIV;
      end
      ST_INC_DIV: if (div_st.done) state_next = ST_INC_ADD;
      ST_INC_ADD: begin
        mul_start  = 1'b1;
        mul_a      = MUL_AW'(prop_gain);
        mul_b      = MUL_BW'(err_mag);
        state_next = ST_CUT_MUL;
      end
      ST_CUT_MUL: if (mul_st.done) state_next = ST_POWER;
      ST_POWER:   state_next = ST_DEN_GO;
      ST_DEN_GO: begin
        if (fast) begin
          mul_start  = 1'b1;
          mul_a      = MUL_AW'(psi);
          mul_b      = MUL_BW'(sp[SPEED_W-2:0]);
          state_next = ST_DEN_MUL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DEN_MUL: if (mul_st.done) state_next = ST_CUR_GO;
      ST_CUR_GO: begin
        if (den == '0) begin
          state_next = ST_EMIT;
        end else begin
          div_start  = 1'b1;
          div_num    = {7'b0, power, 25'b0};
          div_den    = den;
          state_next = ST_CUR_DIV;
        end
      end
      ST_CUR_DIV: if (div_st.done) state_next = ST_EMIT;
      ST_EMIT:    if (!limit.valid || limit.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator  <= '0;
      limit.valid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!limit.valid || limit.ready)) begin
        limit.valid <= 1'b1;
      end else if (limit.ready) begin
        limit.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            wt <= sample.winding_temp;
            mt <= sample.magnet_temp;
            fx <= sample.flux_estimate;
            sp <= sample.elec_speed;
          end
        end
        ST_PREP: begin
          cold    <= tctl < 15'(knee_temp);
          err_neg <= err[15];
          err_mag <= err[15] ? 16'(-err) : 16'(err);
          iq      <= max_current;
        end
        ST_DECAY: begin
          if (mul_st.done) begin
            integrator <= mul_prod[47:16];
            power      <= full_power;
          end
        end
        ST_INC_MUL: begin
          if (mul_st.done) begin
            inc_neg   <= np[DIV_W-1];
            div_num_r <= np[DIV_W-1] ? DIV_W'(-np + 4) : DIV_W'(np);
          end
        end
        ST_INC_DIV: begin
          if (div_st.done) begin
            inc <= inc_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          end
        end
        ST_INC_ADD: begin
          if (acc[DIV_W]) begin
            integrator <= '0;
          end else if (acc > $signed({17'b0, hi})) begin
            integrator <= hi;
          end else begin
            integrator <= acc[INTEG_W-1:0];
          end
        end
        ST_CUT_MUL: begin
          if (mul_st.done) begin
            cut <= cut_s[49] ? '0 : cut_s[48:0];
          end
        end
        ST_POWER: begin
          priority if (x < floor_s) begin
            power <= floor_power;
          end else if (x > full_s) begin
            power <= full_power;
          end else begin
            power <= x[39:24];
          end
        end
        ST_DEN_MUL: begin
          if (mul_st.done) begin
            den <= {mul_prod[DIV_W-2:0], 1'b0} + mul_prod[DIV_W-1:0];
          end
        end
        ST_CUR_DIV: begin
          if (div_st.done && (div_quo < DIV_W'(max_current))) begin
            iq <= div_quo[CUR_W-1:0];
          end
        end
        ST_EMIT: begin
          if (!limit.valid || limit.ready) begin
            limit.power_limit   <= power;
            limit.current_limit <= iq;
          end
        end
        default: ;
      endcase
    end
  end

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!mul_st.busy && !div_st.busy))
    else $error("arithmetic unit busy while idle");

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_PREP))
    else $error("accepted transaction not started");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!limit.valid || limit.ready)) |=> limit.valid)
    else $error("result not presented");

  a_single_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !div_start)
    else $error("both units started together");

endmodule
